### rtl/scu_pkg.sv
// shared types, constants and tables for the shard combination unranking block
// used by every module under rtl; depends on nothing
package scu_pkg;

    localparam int HASH_W        = 32;
    localparam int CFG_W         = 6;
    localparam int CFG_ADDR_W    = 1;
    localparam int IDX_W         = 5;
    localparam int CC_W          = 30;
    localparam int PROD_W        = CC_W + CFG_W;
    localparam int SHIFT_W       = 3;
    localparam int INV_W         = 32;
    localparam int MOD_CNT_W     = 5;
    localparam int MAX_HOSTS_DEF = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_HOST_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHARD_REQ  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CC_ISSUE,
        S_CC_WAIT,
        S_MOD,
        S_FIRST,
        S_STEP_WAIT,
        S_TEST
    } state_t;

    // operand sets for the exact divide unit
    typedef enum logic [1:0] {
        EX_CC,
        EX_FIRST,
        EX_DOWN,
        EX_DIAG
    } ex_op_t;

    typedef struct packed {
        logic   load_item;
        logic   cc_store;
        logic   mod_step;
        logic   unrank_init;
        logic   ex_start;
        ex_op_t ex_op;
        logic   b_load;
        logic   i_inc;
        logic   c_dec;
        logic   emit;
    } cmd_t;

    typedef struct packed {
        logic k_zero;
        logic cache_hit;
        logic i_eq_k;
        logic mod_last;
        logic ex_done;
        logic need_step;
        logic j_is_one;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [INV_W-1:0]   inv;
    } recip_t;

    // exact division by d: drop the power of two, then multiply by the
    // inverse of the odd part modulo 2^32
    function automatic recip_t scu_recip(input logic [CFG_W-1:0] d);
        recip_t           r;
        logic [CFG_W-1:0] odd;
        if (d[0]) begin
            r.shift = 3'd0;
        end else if (d[1]) begin
            r.shift = 3'd1;
        end else if (d[2]) begin
            r.shift = 3'd2;
        end else if (d[3]) begin
            r.shift = 3'd3;
        end else if (d[4]) begin
            r.shift = 3'd4;
        end else begin
            r.shift = 3'd5;
        end
        odd = d >> r.shift;
        case (odd[4:0])
            5'd3:    r.inv = 32'hAAAAAAAB;
            5'd5:    r.inv = 32'hCCCCCCCD;
            5'd7:    r.inv = 32'hB6DB6DB7;
            5'd9:    r.inv = 32'h38E38E39;
            5'd11:   r.inv = 32'hBA2E8BA3;
            5'd13:   r.inv = 32'hC4EC4EC5;
            5'd15:   r.inv = 32'hEEEEEEEF;
            5'd17:   r.inv = 32'hF0F0F0F1;
            5'd19:   r.inv = 32'h286BCA1B;
            5'd21:   r.inv = 32'h3CF3CF3D;
            5'd23:   r.inv = 32'hE9BD37A7;
            5'd25:   r.inv = 32'hC28F5C29;
            5'd27:   r.inv = 32'h684BDA13;
            5'd29:   r.inv = 32'h4F72C235;
            5'd31:   r.inv = 32'hBDEF7BDF;
            default: r.inv = 32'h00000001;
        endcase
        return r;
    endfunction

endpackage

### rtl/scu_exdiv.sv
// two-stage exact divide unit: q = b * m / d where the quotient is known exact
// depends on scu_pkg (reciprocal table)
module scu_exdiv (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [scu_pkg::CC_W-1:0]  b,
    input  logic [scu_pkg::CFG_W-1:0] m,
    input  logic [scu_pkg::CFG_W-1:0] d,
    output logic                      done,
    output logic [scu_pkg::CC_W-1:0]  q
);
    import scu_pkg::*;

    logic              v1_reg, v2_reg;
    logic [PROD_W-1:0] p_reg, p_next;
    recip_t            rc_reg, rc_next;
    logic [CC_W-1:0]   q_reg, q_next;
    logic [INV_W-1:0]  shifted;
    logic [INV_W-1:0]  lo;

    // stage 1: small multiply and reciprocal lookup
    always_comb begin
        p_next  = PROD_W'(b) * PROD_W'(m);
        rc_next = scu_recip(d);
    end

    // stage 2: low half of the inverse product is the exact quotient
    always_comb begin
        shifted = INV_W'(p_reg >> rc_reg.shift);
        lo      = shifted * rc_reg.inv;
        q_next  = lo[CC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg  <= p_next;
        rc_reg <= rc_next;
        q_reg  <= q_next;
    end

    assign done = v2_reg;
    assign q    = q_reg;

endmodule

### rtl/scu_dp.sv
// datapath: config registers, cached C(n,k), remainder loop, unrank registers,
// output register; depends on scu_pkg and scu_exdiv
module scu_dp #(
    parameter int MAX_HOSTS = scu_pkg::MAX_HOSTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [scu_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [scu_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [scu_pkg::HASH_W-1:0]     s_request_hash,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [scu_pkg::IDX_W-1:0]      m_host_index,
    output logic                           m_last,
    input  scu_pkg::cmd_t                  cmd,
    output scu_pkg::stat_t                 stat
);
    import scu_pkg::*;

    localparam logic [CFG_W-1:0] MaxN = CFG_W'(MAX_HOSTS);

    logic [CFG_W-1:0]     host_count_reg, host_count_next;
    logic [CFG_W-1:0]     shard_req_reg, shard_req_next;
    logic [CFG_W-1:0]     cfh_reg, cfh_next;
    logic [CC_W-1:0]      cc_reg, cc_next;
    logic [CFG_W-1:0]     n_reg, n_next;
    logic [CFG_W-1:0]     k_reg, k_next;
    logic [CFG_W-1:0]     i_reg, i_next;
    logic [CFG_W-1:0]     c_reg, c_next;
    logic [CFG_W-1:0]     j_reg, j_next;
    logic [CC_W-1:0]      b_reg, b_next;
    logic [CC_W-1:0]      rank_reg, rank_next;
    logic [HASH_W-1:0]    hash_reg, hash_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]     out_idx_reg, out_idx_next;
    logic                 out_last_reg, out_last_next;

    logic [CFG_W-1:0]     n_eff, k_eff;
    logic [CC_W:0]        trial;
    logic [CC_W-1:0]      ex_b;
    logic [CFG_W-1:0]     ex_m, ex_d;
    logic                 ex_done;
    logic [CC_W-1:0]      ex_q;

    always_comb begin
        n_eff = (host_count_reg > MaxN) ? MaxN : host_count_reg;
        k_eff = (shard_req_reg > n_eff) ? n_eff : shard_req_reg;
    end

    // operand select for the divide unit
    always_comb begin
        case (cmd.ex_op)
            EX_CC: begin
                ex_b = b_reg;
                ex_m = n_reg - i_reg;
                ex_d = i_reg + CFG_W'(1);
            end
            EX_FIRST: begin
                ex_b = cc_reg;
                ex_m = n_reg - k_reg;
                ex_d = n_reg;
            end
            EX_DOWN: begin
                ex_b = b_reg;
                ex_m = c_reg - j_reg;
                ex_d = c_reg;
            end
            default: begin
                ex_b = b_reg;
                ex_m = j_reg;
                ex_d = c_reg;
            end
        endcase
    end

    scu_exdiv u_exdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.ex_start),
        .b       (ex_b),
        .m       (ex_m),
        .d       (ex_d),
        .done    (ex_done),
        .q       (ex_q)
    );

    // config and cache
    always_comb begin
        host_count_next = host_count_reg;
        shard_req_next  = shard_req_reg;
        cfh_next        = cfh_reg;
        cc_next         = cc_reg;
        if (cfg_we) begin
            cfh_next = '0;
            unique case (cfg_addr)
                REG_HOST_COUNT: host_count_next = cfg_wdata;
                REG_SHARD_REQ:  shard_req_next  = cfg_wdata;
                default: ;
            endcase
        end else if (cmd.cc_store) begin
            cc_next  = b_reg;
            cfh_next = n_reg;
        end
    end

    // remainder step: shift one hash bit in, subtract when it fits
    assign trial = {rank_reg, hash_reg[HASH_W-1]};

    always_comb begin
        n_next        = n_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        c_next        = c_reg;
        j_next        = j_reg;
        b_next        = b_reg;
        rank_next     = rank_reg;
        hash_next     = hash_reg;
        mod_cnt_next  = mod_cnt_reg;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (cmd.load_item) begin
            n_next       = n_eff;
            k_next       = k_eff;
            hash_next    = s_request_hash;
            rank_next    = '0;
            mod_cnt_next = '0;
            b_next       = CC_W'(1);
            i_next       = '0;
        end
        if (cmd.mod_step) begin
            hash_next    = hash_reg << 1;
            mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
            if (trial >= {1'b0, cc_reg}) begin
                rank_next = CC_W'(trial - {1'b0, cc_reg});
            end else begin
                rank_next = trial[CC_W-1:0];
            end
        end
        if (cmd.unrank_init) begin
            c_next = n_reg - CFG_W'(1);
            j_next = k_reg;
        end
        if (cmd.b_load) begin
            b_next = ex_q;
        end
        if (cmd.i_inc) begin
            i_next = i_reg + CFG_W'(1);
        end
        if (cmd.c_dec) begin
            c_next = c_reg - CFG_W'(1);
        end
        if (cmd.emit) begin
            out_idx_next  = c_reg[IDX_W-1:0];
            out_last_next = (j_reg == CFG_W'(1));
            m_valid_next  = 1'b1;
            rank_next     = rank_reg - b_reg;
            j_next        = j_reg - CFG_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_count_reg <= CFG_W'(1);
            shard_req_reg  <= CFG_W'(1);
            cfh_reg        <= '0;
            cc_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            host_count_reg <= host_count_next;
            shard_req_reg  <= shard_req_next;
            cfh_reg        <= cfh_next;
            cc_reg         <= cc_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        c_reg        <= c_next;
        j_reg        <= j_next;
        b_reg        <= b_next;
        rank_reg     <= rank_next;
        hash_reg     <= hash_next;
        mod_cnt_reg  <= mod_cnt_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        stat.k_zero    = (k_eff == '0);
        stat.cache_hit = (cfh_reg == n_eff) && (cc_reg != '0);
        stat.i_eq_k    = (i_reg == k_reg);
        stat.mod_last  = (mod_cnt_reg == '1);
        stat.ex_done   = ex_done;
        stat.need_step = (c_reg >= j_reg) && (b_reg > rank_reg);
        stat.j_is_one  = (j_reg == CFG_W'(1));
        stat.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_host_index = out_idx_reg;
    assign m_last       = out_last_reg;

endmodule

### rtl/scu_ctrl.sv
// controller state machine: sequences cache refresh, remainder and unrank steps
// depends on scu_pkg (state, command and status types)
module scu_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  scu_pkg::stat_t stat,
    output scu_pkg::cmd_t  cmd
);
    import scu_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (stat.k_zero) begin
                        state_next = S_IDLE;
                    end else if (stat.cache_hit) begin
                        state_next = S_MOD;
                    end else begin
                        state_next = S_CC_ISSUE;
                    end
                end
            end
            S_CC_ISSUE: state_next = stat.i_eq_k ? S_MOD : S_CC_WAIT;
            S_CC_WAIT: begin
                if (stat.ex_done) begin
                    state_next = S_CC_ISSUE;
                end
            end
            S_MOD: begin
                if (stat.mod_last) begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST: state_next = S_STEP_WAIT;
            S_STEP_WAIT: begin
                if (stat.ex_done) begin
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                if (stat.need_step) begin
                    state_next = S_STEP_WAIT;
                end else if (stat.out_free) begin
                    state_next = stat.j_is_one ? S_IDLE : S_STEP_WAIT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            S_CC_ISSUE: begin
                if (stat.i_eq_k) begin
                    cmd.cc_store = 1'b1;
                end else begin
                    cmd.ex_start = 1'b1;
                    cmd.ex_op    = EX_CC;
                end
            end
            S_CC_WAIT: begin
                cmd.b_load = stat.ex_done;
                cmd.i_inc  = stat.ex_done;
            end
            S_MOD: cmd.mod_step = 1'b1;
            S_FIRST: begin
                cmd.ex_start    = 1'b1;
                cmd.ex_op       = EX_FIRST;
                cmd.unrank_init = 1'b1;
            end
            S_STEP_WAIT: cmd.b_load = stat.ex_done;
            S_TEST: begin
                if (stat.need_step) begin
                    cmd.ex_start = 1'b1;
                    cmd.ex_op    = EX_DOWN;
                    cmd.c_dec    = 1'b1;
                end else if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (!stat.j_is_one) begin
                        cmd.ex_start = 1'b1;
                        cmd.ex_op    = EX_DIAG;
                        cmd.c_dec    = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/shard_combination_unrank_top.sv
// shard combination unranking top level, built from scu_pkg, scu_ctrl and scu_dp (with scu_exdiv)
// the run to the last index lengthens with n-1 minus the smallest index,
//   with a refresh of C(n,k) and with any output stall
// a request is taken only in idle, after the divide steps and the 32-step remainder loop of the
//   one before; the next request is taken while the last index waits
// reset: synchronous active-low aresetn; both config registers return to 1, cache invalid
module shard_combination_unrank_top #(
    parameter int MAX_HOSTS = scu_pkg::MAX_HOSTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes, which the user must make only while idle; the block does not enforce it
    input  logic                           cfg_we,
    input  logic [scu_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [scu_pkg::CFG_W-1:0]      cfg_wdata,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [scu_pkg::HASH_W-1:0]     s_request_hash,
    // host index channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [scu_pkg::IDX_W-1:0]      m_host_index,
    output logic                           m_last
);
    import scu_pkg::*;

    // command and status between controller and datapath
    cmd_t  cmd;
    stat_t stat;

    // controller: cache refresh, remainder loop, then one unrank step per divide
    scu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: registers, remainder, exact divide unit and the output register
    scu_dp #(
        .MAX_HOSTS (MAX_HOSTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_request_hash (s_request_hash),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_host_index   (m_host_index),
        .m_last         (m_last),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

### rtl/scu_checker.sv
// port-level checker for the shard combination unranking top level, with its bind
// depends on scu_pkg and shard_combination_unrank_top (bind target)
module scu_checker #(
    parameter int MAX_HOSTS = scu_pkg::MAX_HOSTS_DEF
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_host_index,
    input logic       m_last
);

    // stalled index transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_host_index) && $stable(m_last))
        else $error("stalled index transaction changed");

    // a non-final index always has a smaller one after it, so it is never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_host_index != 5'd0)
        else $error("non-final index is zero");

    // indices stay inside the host range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {1'b0, m_host_index} < 6'(MAX_HOSTS))
        else $error("index beyond host range");

    // reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind shard_combination_unrank_top scu_checker #(.MAX_HOSTS(MAX_HOSTS)) u_checker (.*);

### test/testbench.sv
// self-checking testbench for shard_combination_unrank_top: a directed table, then random
// phases of requests under several host and shard settings, checked against a local predictor
// depends on scu_pkg and the rtl under rtl/
`timescale 1ns / 1ps

module testbench;
    import scu_pkg::*;

    // how the expected indices of a directed row are obtained
    typedef enum logic [1:0] {
        OUT_PREDICTED,   // worked out by the predictor
        OUT_NOTHING,     // empty shard, no index at all
        OUT_ONE,         // single index, typed into the row
        OUT_DESCENDING   // every host, from n-1 down to 0
    } outcome_t;

    typedef struct packed {
        logic [CFG_W-1:0]  hosts;
        logic [CFG_W-1:0]  shard;
        logic [HASH_W-1:0] hash;
        outcome_t          outcome;
        logic [IDX_W-1:0]  host;
    } stim_row_t;

    typedef struct packed {
        logic [IDX_W-1:0] host_index;
        logic             last;
    } host_pick_t;

    localparam int RANDOM_ITEMS    = 450;
    localparam int TAIL_ITEMS      = 60;    // closing stretch without idling
    localparam int LATENCY_PAUSE   = 400;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int WATCHDOG_LIMIT  = 4000;

    // directed rows: reset settings, field extremes, zero sizes, saturation and clipping
    localparam stim_row_t DIRECTED_ROWS [22] = '{
        '{6'd1,  6'd1,  32'hDEADBEEF, OUT_ONE,        5'd0},
        '{6'd1,  6'd1,  32'hFFFFFFFF, OUT_ONE,        5'd0},
        '{6'd32, 6'd1,  32'h00000000, OUT_ONE,        5'd0},
        '{6'd32, 6'd1,  32'hFFFFFFFF, OUT_ONE,        5'd31},
        '{6'd63, 6'd1,  32'h00012345, OUT_ONE,        5'd5},
        '{6'd40, 6'd1,  32'hFFFFFFE1, OUT_ONE,        5'd1},
        '{6'd0,  6'd5,  32'hFFFFFFFF, OUT_NOTHING,    5'd0},
        '{6'd5,  6'd0,  32'h12345678, OUT_NOTHING,    5'd0},
        '{6'd0,  6'd0,  32'h00000000, OUT_NOTHING,    5'd0},
        '{6'd32, 6'd32, 32'hFFFFFFFF, OUT_DESCENDING, 5'd0},
        '{6'd32, 6'd63, 32'h00000000, OUT_DESCENDING, 5'd0},
        '{6'd4,  6'd9,  32'hA5A5A5A5, OUT_DESCENDING, 5'd0},
        '{6'd32, 6'd16, 32'hFFFFFFFF, OUT_PREDICTED,  5'd0},
        '{6'd32, 6'd16, 32'h00000000, OUT_PREDICTED,  5'd0},
        '{6'd32, 6'd16, 32'd601080389, OUT_PREDICTED, 5'd0},
        '{6'd32, 6'd16, 32'd601080390, OUT_PREDICTED, 5'd0},
        '{6'd32, 6'd31, 32'h7FFFFFFF, OUT_PREDICTED,  5'd0},
        '{6'd32, 6'd2,  32'h80000000, OUT_PREDICTED,  5'd0},
        '{6'd17, 6'd3,  32'h55555555, OUT_PREDICTED,  5'd0},
        '{6'd2,  6'd1,  32'h00000003, OUT_ONE,        5'd1},
        '{6'd33, 6'd33, 32'h00000007, OUT_DESCENDING, 5'd0},
        '{6'd1,  6'd63, 32'hFFFFFFFF, OUT_ONE,        5'd0}
    };

    // every input has a known value from time zero
    logic              aclk;
    logic              aresetn        = 1'b0;
    logic              cfg_we         = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
    logic [CFG_W-1:0]  cfg_wdata      = '0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [HASH_W-1:0] s_request_hash = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [IDX_W-1:0]  m_host_index;
    logic              m_last;

    // predictor copy of the registers and the cached binomial
    logic [CFG_W-1:0]  cfg_hosts     = 6'd1;
    logic [CFG_W-1:0]  cfg_shard     = 6'd1;
    logic [CC_W-1:0]   cached_count  = '0;
    logic [CFG_W-1:0]  cached_hosts  = '0;

    host_pick_t        expected_hosts [$];
    int                mismatch_count    = 0;
    int                quiet_cycles      = 0;
    bit                idle_enable       = 1'b1;
    bit                hold_off_request  = 1'b0;

    shard_combination_unrank_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_request_hash (s_request_hash),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_host_index   (m_host_index),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // exact binomial, 0 when b exceeds a
    function automatic longint unsigned binomial(input int unsigned a, input int unsigned b);
        longint unsigned r;
        int unsigned     m;
        r = 1;
        if (b > a) return 0;
        m = (b > a - b) ? a - b : b;
        for (int unsigned i = 0; i < m; i++) r = r * (a - i) / (i + 1);
        return r;
    endfunction

    // reduce the hash modulo C(n,k) and unrank it in colex order, largest index first;
    // the cache is refreshed on a miss whether or not indices are kept; they are queued only when asked
    function automatic void predict_shard(input logic [HASH_W-1:0] hash, input bit keep);
        int unsigned     n;
        int unsigned     k;
        int unsigned     c;
        longint unsigned rank;
        host_pick_t      pick;
        n = (cfg_hosts > MAX_HOSTS_DEF) ? MAX_HOSTS_DEF : cfg_hosts;
        k = (cfg_shard > n) ? n : cfg_shard;
        if (n == 0 || k == 0) return;
        if (cached_hosts != n || cached_count == 0) begin
            cached_count = CC_W'(binomial(n, k));
            cached_hosts = CFG_W'(n);
        end
        if (cached_count == 0) return;
        rank = 64'(hash) % 64'(cached_count);
        c = n;
        for (int unsigned j = k; j > 0; j--) begin
            // largest c below the previous pick with C(c,j) not above the rank
            c = c - 1;
            while (c >= j && binomial(c, j) > rank) c--;
            rank -= binomial(c, j);
            pick.host_index = IDX_W'(c);
            pick.last       = (j == 1);
            if (keep) expected_hosts = {expected_hosts, pick};
        end
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $time, what);
    endtask

    // stop offering, wait for every outstanding index, then let the block settle
    task automatic drain_requests(input int settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_hosts.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // registers are only written with the block idle; both are written back to back
    task automatic configure_shard(input logic [CFG_W-1:0] hosts, input logic [CFG_W-1:0] shard);
        drain_requests(LATENCY_PAUSE);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_HOST_COUNT;
        cfg_wdata <= hosts;
        @(posedge aclk);
        cfg_addr  <= REG_SHARD_REQ;
        cfg_wdata <= shard;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        // any write drops the cached binomial
        cfg_hosts    = hosts;
        cfg_shard    = shard;
        cached_hosts = '0;
    endtask

    // offer one request transaction and queue what it must produce once it is taken
    task automatic send_request(input logic [HASH_W-1:0] hash, input outcome_t outcome,
                                input logic [IDX_W-1:0] typed_host);
        int unsigned n_eff;
        host_pick_t  pick;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        // valid stays high from the previous transaction when there is no gap
        s_valid        <= 1'b1;
        s_request_hash <= hash;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_shard(hash, outcome == OUT_PREDICTED);
        case (outcome)
            OUT_ONE: begin
                pick.host_index = typed_host;
                pick.last       = 1'b1;
                expected_hosts  = {expected_hosts, pick};
            end
            OUT_DESCENDING: begin
                n_eff = (cfg_hosts > MAX_HOSTS_DEF) ? MAX_HOSTS_DEF : cfg_hosts;
                for (int i = int'(n_eff) - 1; i >= 0; i--) begin
                    pick.host_index = IDX_W'(i);
                    pick.last       = (i == 0);
                    expected_hosts  = {expected_hosts, pick};
                end
            end
            default: ;
        endcase
    endtask

    // index receiver: short random stalls, runs of ready, and one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            if (hold_off_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_request = 1'b0;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // compare each index transaction with the oldest expectation
    always @(posedge aclk) begin : host_monitor
        host_pick_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hosts.size() == 0) begin
                flag_mismatch($sformatf("unexpected index %0d last %0d", m_host_index, m_last));
            end else begin
                want = expected_hosts[0];
                expected_hosts.delete(0);
                if (want.host_index !== m_host_index || want.last !== m_last)
                    flag_mismatch($sformatf("index %0d last %0d, expected index %0d last %0d",
                                            m_host_index, m_last, want.host_index, want.last));
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // main stimulus
    initial begin
        logic [CFG_W-1:0]  hosts;
        logic [CFG_W-1:0]  shard;
        logic [HASH_W-1:0] hash;
        int unsigned       n_eff;
        int unsigned       k_eff;
        int                phase_items;
        int                counted;
        int                phase;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, starting on the reset values of both registers
        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].hosts != cfg_hosts || DIRECTED_ROWS[r].shard != cfg_shard)
                configure_shard(DIRECTED_ROWS[r].hosts, DIRECTED_ROWS[r].shard);
            send_request(DIRECTED_ROWS[r].hash, DIRECTED_ROWS[r].outcome,
                         DIRECTED_ROWS[r].host);
        end

        // random phases, each under its own register setting
        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            if (phase == 0) begin
                // largest binomial first
                hosts = 6'd32;
                shard = 6'd16;
            end else begin
                case (phase == 1 ? 9 : $urandom_range(0, 9))
                    0: begin
                        // empty shard: zero host count or zero shard size
                        if ($urandom_range(0, 1)) begin
                            hosts = 6'd0;
                            shard = CFG_W'($urandom_range(0, 63));
                        end else begin
                            hosts = CFG_W'($urandom_range(1, 63));
                            shard = 6'd0;
                        end
                    end
                    1: begin
                        // host count beyond the maximum saturates
                        hosts = CFG_W'($urandom_range(33, 63));
                        shard = CFG_W'($urandom_range(1, 63));
                    end
                    2: begin
                        // shard size clipped to the host count
                        hosts = CFG_W'($urandom_range(1, 32));
                        shard = CFG_W'($urandom_range(hosts, 63));
                    end
                    default: begin
                        hosts = CFG_W'($urandom_range(1, 32));
                        shard = CFG_W'($urandom_range(1, hosts));
                    end
                endcase
            end
            configure_shard(hosts, shard);
            n_eff       = (hosts > MAX_HOSTS_DEF) ? MAX_HOSTS_DEF : hosts;
            k_eff       = (shard > n_eff) ? n_eff : shard;
            phase_items = (k_eff == 0) ? 4 : $urandom_range(20, 60);

            // long receiver hold-off while requests keep coming, so the input stalls
            if (phase == 1) hold_off_request = 1'b1;

            for (int i = 0; i < phase_items; i++) begin
                idle_enable = (counted + TAIL_ITEMS < RANDOM_ITEMS);
                // one pause mid-phase until every index is back
                if (phase == 3 && i == phase_items / 2) drain_requests(0);
                case ($urandom_range(0, 3))
                    0:       hash = HASH_W'($urandom_range(0, 255));
                    1:       hash = 32'hFFFFFFFF - HASH_W'($urandom_range(0, 255));
                    default: hash = $urandom();
                endcase
                send_request(hash, OUT_PREDICTED, '0);
                if (k_eff != 0) counted++;
            end
            phase++;
        end

        // wait out every outstanding index, then a latency's worth for strays
        drain_requests(LATENCY_PAUSE);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
